[rtl/core/script_token_lexer_unit_macros.svh]
// assertion macros for the script token lexer unit
// used by the top level only; needs nothing else
`ifndef SCRIPT_TOKEN_LEXER_UNIT_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// implication in the same cycle
`define STLX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stlx check failed");
// implication into the next cycle
`define STLX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stlx check failed");
`else
`define STLX_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STLX_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/stlx_pkg.sv]
// shared types, codes and helper functions of the script token lexer
// no dependencies
package stlx_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int LINE_BITS = 16;
   localparam int KEYWORD_CHARS = 8;
   localparam int WIDE_BITS = 33;
   localparam int FIELD_BITS = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int MAX_TOKENS = 3;

   // token kinds
   localparam logic [5:0] KIND_LPAREN = 6'd0;
   localparam logic [5:0] KIND_RPAREN = 6'd1;
   localparam logic [5:0] KIND_LBRACE = 6'd2;
   localparam logic [5:0] KIND_RBRACE = 6'd3;
   localparam logic [5:0] KIND_SEMI = 6'd4;
   localparam logic [5:0] KIND_COMMA = 6'd5;
   localparam logic [5:0] KIND_MINUS = 6'd6;
   localparam logic [5:0] KIND_PLUS = 6'd7;
   localparam logic [5:0] KIND_SLASH = 6'd8;
   localparam logic [5:0] KIND_STAR = 6'd9;
   localparam logic [5:0] KIND_CARET = 6'd10;
   localparam logic [5:0] KIND_PERCENT = 6'd11;
   localparam logic [5:0] KIND_BANG = 6'd12;
   localparam logic [5:0] KIND_BANG_EQ = 6'd13;
   localparam logic [5:0] KIND_EQ = 6'd14;
   localparam logic [5:0] KIND_EQ_EQ = 6'd15;
   localparam logic [5:0] KIND_LESS_EQ = 6'd16;
   localparam logic [5:0] KIND_SHL = 6'd17;
   localparam logic [5:0] KIND_GREATER_EQ = 6'd18;
   localparam logic [5:0] KIND_SHR = 6'd19;
   localparam logic [5:0] KIND_IDENT = 6'd20;
   localparam logic [5:0] KIND_STRING = 6'd21;
   localparam logic [5:0] KIND_INT = 6'd22;
   localparam logic [5:0] KIND_FLOAT = 6'd23;
   localparam logic [5:0] KIND_ELSE = 6'd24;
   localparam logic [5:0] KIND_FALSE = 6'd25;
   localparam logic [5:0] KIND_FOR = 6'd26;
   localparam logic [5:0] KIND_FUNCTION = 6'd27;
   localparam logic [5:0] KIND_IF = 6'd28;
   localparam logic [5:0] KIND_LET = 6'd29;
   localparam logic [5:0] KIND_NULL = 6'd30;
   localparam logic [5:0] KIND_PRINT = 6'd31;
   localparam logic [5:0] KIND_RETURN = 6'd32;
   localparam logic [5:0] KIND_TRUE = 6'd33;
   localparam logic [5:0] KIND_WHILE = 6'd34;
   localparam logic [5:0] KIND_END = 6'd35;
   localparam logic [5:0] KIND_ERROR = 6'd36;

   // error kinds
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'd0,
      MODE_IDENT = 4'd1,
      MODE_INT = 4'd2,
      MODE_INT_DOT = 4'd3,
      MODE_FLOAT = 4'd4,
      MODE_STRING = 4'd5,
      MODE_COMMENT = 4'd6,
      MODE_SLASH = 4'd7,
      MODE_BANG = 4'd8,
      MODE_EQUAL = 4'd9,
      MODE_LESS = 4'd10,
      MODE_GREATER = 4'd11
   } lex_mode_type;

   typedef struct packed {
      logic        last;
      logic [15:0] line;
      logic [15:0] length;
      logic [15:0] start;
      logic [1:0]  err;
      logic [5:0]  kind;
   } token_type;

   // tokens produced by one source byte
   typedef struct packed {
      logic       valid;
      logic [1:0] count;
      token_type  tok2;
      token_type  tok1;
      token_type  tok0;
   } push_type;

   typedef struct packed {
      logic [QPTR_BITS:0] level;
      logic               room;
   } queue_status_type;

   // clip a widened value to a 16-bit field
   function automatic logic [FIELD_BITS-1:0] sat_field(input logic [WIDE_BITS-1:0] v);
      logic [FIELD_BITS-1:0] r;
      r = (v > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : v[FIELD_BITS-1:0];
      return r;
   endfunction

   // saturated distance from start to end
   function automatic logic [FIELD_BITS-1:0] span(input logic [WIDE_BITS-1:0] st,
                                                  input logic [WIDE_BITS-1:0] en);
      logic [FIELD_BITS-1:0] r;
      r = (en > st) ? sat_field(en - st) : '0;
      return r;
   endfunction

   // compare the stored prefix with one keyword, word right-aligned in w
   function automatic logic word_is(input logic [8*KEYWORD_CHARS-1:0] p,
                                    input logic [3:0] len,
                                    input logic [8*KEYWORD_CHARS-1:0] w,
                                    input logic [3:0] n);
      logic       ok;
      logic [2:0] idx;
      ok = (len == n);
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         idx = 3'(n - 4'd1 - 4'(i));
         if (4'(i) < n && p[8*i +: 8] != w[8*idx +: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [5:0] keyword_kind(input logic [8*KEYWORD_CHARS-1:0] p,
                                               input logic [3:0] len);
      logic [5:0] k;
      k = KIND_IDENT;
      if (word_is(p, len, 64'("else"), 4'd4)) k = KIND_ELSE;
      if (word_is(p, len, 64'("false"), 4'd5)) k = KIND_FALSE;
      if (word_is(p, len, 64'("for"), 4'd3)) k = KIND_FOR;
      if (word_is(p, len, 64'("function"), 4'd8)) k = KIND_FUNCTION;
      if (word_is(p, len, 64'("if"), 4'd2)) k = KIND_IF;
      if (word_is(p, len, 64'("let"), 4'd3)) k = KIND_LET;
      if (word_is(p, len, 64'("null"), 4'd4)) k = KIND_NULL;
      if (word_is(p, len, 64'("print"), 4'd5)) k = KIND_PRINT;
      if (word_is(p, len, 64'("return"), 4'd6)) k = KIND_RETURN;
      if (word_is(p, len, 64'("true"), 4'd4)) k = KIND_TRUE;
      if (word_is(p, len, 64'("while"), 4'd5)) k = KIND_WHILE;
      return k;
   endfunction

endpackage

[rtl/core/script_token_lexer_unit.sv]
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata[7:0] source_byte
// rsp_      out  rsp_tvalid/rsp_tready  tdata kind,error,start,length,line; tlast last_token
//
// one source byte is taken per cycle while the token queue has room for three tokens
// a token reaches rsp_ through the queue memory and then the output register; the output
// register drains the queue at one token a cycle while rsp_tready is high, so bytes giving
// two or three tokens slow intake to the output rate
// reset is synchronous: scanner idle, offset 0, line 1, queue empty
// a stalled rsp_ side fills the queue and then holds req_tready low
`include "script_token_lexer_unit_macros.svh"
module script_token_lexer_unit
   import stlx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [5:0] token_kind, [7:6] error_kind,
                                    // [23:8] token_start, [39:24] token_length,
                                    // [55:40] line_number
   output logic        rsp_tlast    // last_token
);

   push_type         push;
   queue_status_type q_status;
   logic             head_valid;
   token_type        head;
   logic             pop;
   logic             accept;

   assign req_tready = q_status.room;
   assign accept = req_tvalid && req_tready;

   stlx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_tdata),
      .push        (push)
   );

   stlx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .status     (q_status)
   );

   stlx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   `STLX_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, q_status.level <= (QPTR_BITS+1)'(QUEUE_DEPTH))
   `STLX_ASSERT_IMP(a_end_is_last, clock, reset, rsp_tvalid && rsp_tdata[5:0] == KIND_END, rsp_tlast)
   `STLX_ASSERT_IMP(a_err_kind, clock, reset, rsp_tvalid && rsp_tdata[7:6] != ERR_NONE, rsp_tdata[5:0] == KIND_ERROR)

endmodule

[rtl/core/stlx_front.sv]
// scanner front: takes one source byte a cycle while accept is high and classifies it into tokens
// depends on stlx_pkg
module stlx_front
   import stlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] source_byte,
   output push_type   push
);

   lex_mode_type          mode_ff, mode_in;
   logic [7:0]            prefix_ff [KEYWORD_CHARS];
   logic [3:0]            ident_len_ff, ident_len_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic                  pf_we;
   logic [2:0]            pf_idx;
   token_type             tk [MAX_TOKENS];
   logic [1:0]            n;

   // byte classes and widened offsets
   logic                  is_alpha, is_num;
   logic [WIDE_BITS-1:0]  cur_w, st_w, dot_w;
   logic [FIELD_BITS-1:0] line16;
   logic [8*KEYWORD_CHARS-1:0] prefix_flat;
   logic [OFFSET_BITS-1:0] cur_inc;
   logic [LINE_BITS-1:0]  line_inc;

   always_comb begin
      is_alpha = (source_byte >= "a" && source_byte <= "z") ||
                 (source_byte >= "A" && source_byte <= "Z") || source_byte == "_";
      is_num = source_byte >= "0" && source_byte <= "9";
      cur_w = WIDE_BITS'(offset_ff);
      st_w = WIDE_BITS'(start_ff);
      dot_w = (offset_ff != '0) ? cur_w - WIDE_BITS'(1) : '0;
      line16 = sat_field(WIDE_BITS'(line_ff));
      cur_inc = (offset_ff == '1) ? offset_ff : offset_ff + OFFSET_BITS'(1);
      line_inc = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
      for (int i = 0; i < KEYWORD_CHARS; i++) prefix_flat[8*i +: 8] = prefix_ff[i];
   end

   // scanning step: mode part then idle rescan
   always_comb begin
      logic consumed;
      mode_in = mode_ff;
      ident_len_in = ident_len_ff;
      start_in = start_ff;
      offset_in = offset_ff;
      line_in = line_ff;
      pf_we = 1'b0;
      pf_idx = ident_len_ff[2:0];
      n = '0;
      consumed = 1'b0;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         tk[i] = '0;
         tk[i].line = line16;
      end

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_alpha || is_num) begin
               pf_we = ident_len_ff < 4'(KEYWORD_CHARS);
               if (ident_len_ff != 4'd15) ident_len_in = ident_len_ff + 4'd1;
               consumed = 1'b1;
            end else begin
               tk[n].kind = keyword_kind(prefix_flat, ident_len_ff);
               tk[n].start = sat_field(st_w);
               tk[n].length = span(st_w, cur_w);
               n = n + 2'd1;
            end
         end
         MODE_INT: begin
            if (is_num) begin
               consumed = 1'b1;
            end else if (source_byte == ".") begin
               mode_in = MODE_INT_DOT;
               consumed = 1'b1;
            end else begin
               tk[n].kind = KIND_INT;
               tk[n].start = sat_field(st_w);
               tk[n].length = span(st_w, cur_w);
               n = n + 2'd1;
            end
         end
         MODE_INT_DOT: begin
            if (is_num) begin
               mode_in = MODE_FLOAT;
               consumed = 1'b1;
            end else begin
               tk[0].kind = KIND_INT;
               tk[0].start = sat_field(st_w);
               tk[0].length = span(st_w, dot_w);
               tk[1].kind = KIND_ERROR;
               tk[1].err = ERR_UNEXPECTED;
               tk[1].start = sat_field(dot_w);
               n = 2'd2;
            end
         end
         MODE_FLOAT: begin
            if (is_num) begin
               consumed = 1'b1;
            end else begin
               tk[n].kind = KIND_FLOAT;
               tk[n].start = sat_field(st_w);
               tk[n].length = span(st_w, cur_w);
               n = n + 2'd1;
            end
         end
         MODE_STRING: begin
            if (source_byte == "\"") begin
               tk[n].kind = KIND_STRING;
               tk[n].start = sat_field(st_w);
               tk[n].length = span(st_w, cur_w + WIDE_BITS'(1));
               n = n + 2'd1;
               mode_in = MODE_IDLE;
               consumed = 1'b1;
            end else if (source_byte == 8'd0) begin
               tk[n].kind = KIND_ERROR;
               tk[n].err = ERR_UNTERMINATED;
               tk[n].start = sat_field(st_w);
               n = n + 2'd1;
            end else begin
               if (source_byte == "\n") line_in = line_inc;
               consumed = 1'b1;
            end
         end
         MODE_COMMENT: begin
            consumed = source_byte != "\n" && source_byte != 8'd0;
         end
         MODE_SLASH: begin
            if (source_byte == "/") begin
               mode_in = MODE_COMMENT;
               consumed = 1'b1;
            end else begin
               tk[n].kind = KIND_SLASH;
               tk[n].start = sat_field(st_w);
               tk[n].length = 16'd1;
               n = n + 2'd1;
            end
         end
         MODE_BANG, MODE_EQUAL: begin
            tk[n].start = sat_field(st_w);
            if (source_byte == "=") begin
               tk[n].kind = (mode_ff == MODE_BANG) ? KIND_BANG_EQ : KIND_EQ_EQ;
               tk[n].length = 16'd2;
               mode_in = MODE_IDLE;
               consumed = 1'b1;
            end else begin
               tk[n].kind = (mode_ff == MODE_BANG) ? KIND_BANG : KIND_EQ;
               tk[n].length = 16'd1;
            end
            n = n + 2'd1;
         end
         MODE_LESS, MODE_GREATER: begin
            tk[n].start = sat_field(st_w);
            if (source_byte == "=") begin
               tk[n].kind = (mode_ff == MODE_LESS) ? KIND_LESS_EQ : KIND_GREATER_EQ;
               tk[n].length = 16'd2;
               mode_in = MODE_IDLE;
               consumed = 1'b1;
            end else if ((mode_ff == MODE_LESS && source_byte == "<") ||
                         (mode_ff == MODE_GREATER && source_byte == ">")) begin
               tk[n].kind = (mode_ff == MODE_LESS) ? KIND_SHL : KIND_SHR;
               tk[n].length = 16'd2;
               mode_in = MODE_IDLE;
               consumed = 1'b1;
            end else begin
               tk[n].kind = KIND_ERROR;
               tk[n].err = ERR_UNEXPECTED;
            end
            n = n + 2'd1;
         end
         default: begin
         end
      endcase

      // byte taken by the mode, or scanned afresh from idle
      if (consumed) begin
         offset_in = cur_inc;
      end else begin
         mode_in = MODE_IDLE;
         if (source_byte == 8'd0) begin
            tk[n].kind = KIND_END;
            tk[n].err = ERR_NONE;
            tk[n].start = sat_field(cur_w);
            tk[n].length = '0;
            n = n + 2'd1;
            offset_in = '0;
            line_in = LINE_BITS'(1);
            start_in = '0;
         end else begin
            start_in = offset_ff;
            offset_in = cur_inc;
            tk[n].start = sat_field(cur_w);
            tk[n].length = 16'd1;
            case (source_byte)
               " ", "\r", "\t": begin
               end
               "\n": line_in = line_inc;
               "(": begin tk[n].kind = KIND_LPAREN; n = n + 2'd1; end
               ")": begin tk[n].kind = KIND_RPAREN; n = n + 2'd1; end
               "{": begin tk[n].kind = KIND_LBRACE; n = n + 2'd1; end
               "}": begin tk[n].kind = KIND_RBRACE; n = n + 2'd1; end
               ";": begin tk[n].kind = KIND_SEMI; n = n + 2'd1; end
               ",": begin tk[n].kind = KIND_COMMA; n = n + 2'd1; end
               "-": begin tk[n].kind = KIND_MINUS; n = n + 2'd1; end
               "+": begin tk[n].kind = KIND_PLUS; n = n + 2'd1; end
               "*": begin tk[n].kind = KIND_STAR; n = n + 2'd1; end
               "^": begin tk[n].kind = KIND_CARET; n = n + 2'd1; end
               "%": begin tk[n].kind = KIND_PERCENT; n = n + 2'd1; end
               "/": mode_in = MODE_SLASH;
               "!": mode_in = MODE_BANG;
               "=": mode_in = MODE_EQUAL;
               "<": mode_in = MODE_LESS;
               ">": mode_in = MODE_GREATER;
               "\"": mode_in = MODE_STRING;
               default: begin
                  if (is_alpha) begin
                     pf_we = 1'b1;
                     pf_idx = '0;
                     ident_len_in = 4'd1;
                     mode_in = MODE_IDENT;
                  end else if (is_num) begin
                     mode_in = MODE_INT;
                  end else begin
                     tk[n].kind = KIND_ERROR;
                     tk[n].err = ERR_UNEXPECTED;
                     tk[n].length = '0;
                     n = n + 2'd1;
                  end
               end
            endcase
         end
      end

      // flag the final token of this byte
      if (n != '0) tk[n - 2'd1].last = 1'b1;
   end

   always_comb begin
      push.valid = accept;
      push.count = n;
      push.tok0 = tk[0];
      push.tok1 = tk[1];
      push.tok2 = tk[2];
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         ident_len_ff <= '0;
         start_ff <= '0;
         offset_ff <= '0;
         line_ff <= LINE_BITS'(1);
      end else if (accept) begin
         mode_ff <= mode_in;
         ident_len_ff <= ident_len_in;
         start_ff <= start_in;
         offset_ff <= offset_in;
         line_ff <= line_in;
      end
   end

   // keyword prefix store
   always_ff @(posedge clock) begin
      if (accept && pf_we) prefix_ff[pf_idx] <= source_byte;
   end

endmodule

[rtl/core/stlx_queue.sv]
// token queue between scanner front and output stage, up to three writes a cycle
// depends on stlx_pkg
module stlx_queue
   import stlx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output logic             head_valid,
   output token_type        head,
   output queue_status_type status
);

   token_type           mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   level_ff, level_in;
   logic [1:0]           n_push;
   logic                 do_pop;
   token_type            entries [MAX_TOKENS];

   always_comb begin
      n_push = push.valid ? push.count : 2'd0;
      do_pop = pop && level_ff != '0;
      entries[0] = push.tok0;
      entries[1] = push.tok1;
      entries[2] = push.tok2;
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(do_pop);
      level_in = level_ff + (QPTR_BITS+1)'(n_push) - (QPTR_BITS+1)'(do_pop);
      head_valid = level_ff != '0;
      head = mem[rd_ptr_ff];
      status.level = level_ff;
      status.room = level_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH - MAX_TOKENS);
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (2'(i) < n_push) mem[QPTR_BITS'(wr_ptr_ff + QPTR_BITS'(i))] <= entries[i];
      end
   end

endmodule

[rtl/core/stlx_back.sv]
// output stage: registers the queue head onto the result stream
// depends on stlx_pkg
module stlx_back
   import stlx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  token_type   head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic      valid_ff, valid_in;
   token_type tok_ff;

   always_comb begin
      pop = head_valid && (!valid_ff || rsp_tready);
      valid_in = pop || (valid_ff && !rsp_tready);
      rsp_tvalid = valid_ff;
      rsp_tdata = {tok_ff.line, tok_ff.length, tok_ff.start, tok_ff.err, tok_ff.kind};
      rsp_tlast = tok_ff.last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) tok_ff <= head;
   end

endmodule
